// ===== rtl/clp_pkg.sv =====
`timescale 1ns / 1ps

package clp_pkg;

  localparam int unsigned MAX_UINTVAR_BYTES_DEF = 5;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned OCTET_W = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [2:0] {
    KIND_LEN     = 3'd0,
    KIND_ID      = 3'd1,
    KIND_NAME    = 3'd2,
    KIND_TERM    = 3'd3,
    KIND_DATA    = 3'd4,
    KIND_IGNORED = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_UVAR  = 3'd1,
    ST_ZERO_LEN  = 3'd2,
    ST_NO_TERM   = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_e;

  typedef struct packed {
    status_e            status;
    logic               cap_end;
    logic [LEN_W-1:0]   cap_length;
    logic [OCTET_W-1:0] value;
    kind_e              kind;
  } result_t;

endpackage

// ===== rtl/capability_list_parser.sv =====
`timescale 1ns / 1ps

// channel   | ports        | tdata (low bit up)                          | tuser | tlast
// ----------+--------------+---------------------------------------------+-------+--------------
// input     | s_axis_*     | octet[7:0]                                  | -     | end_of_buffer
// output    | m_axis_*     | value[7:0] cap_length[39:8] status[42:40]   | kind  | cap_end
//
// One byte is tagged per cycle while s_axis_tready is high; each accepted item yields exactly one result.
// An accepted item's result is registered in the output register, or in the skid entry while it is stalled.
// A two-entry output stage (result register plus skid) absorbs a result while
// the output side stalls; s_axis_tready drops only when both entries are full.
// rst_ni clears the parse state and both output entries.

module capability_list_parser
  import clp_pkg::*;
#(
  parameter int unsigned MAX_UINTVAR_BYTES = MAX_UINTVAR_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [OCTET_W-1:0]     s_axis_tdata,   // octet[7:0]
  input  logic                   s_axis_tlast,   // end_of_buffer
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // value[7:0], cap_length[39:8], status[42:40]
  output logic [2:0]             m_axis_tuser,   // kind[2:0]
  output logic                   m_axis_tlast    // cap_end
);

  typedef enum logic [2:0] {
    PH_LEN    = 3'd0,
    PH_ID     = 3'd1,
    PH_NAME   = 3'd2,
    PH_DATA   = 3'd3,
    PH_IGNORE = 3'd4
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [LEN_W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LEN_W-1:0]   rem_q, rem_d;
  status_e            err_q, err_d;

  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;
  result_t            out_q, out_d;
  result_t            skid_q, skid_d;
  result_t            res;

  logic               in_fire, out_fire, eob;
  logic [OCTET_W-1:0] b;
  logic [LEN_W-1:0]   acc_n, rem_n;
  logic [CNT_W-1:0]   cnt_n;
  phase_e             ph_n;

  assign s_axis_tready = !skid_valid_q;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign b   = s_axis_tdata;
  assign eob = s_axis_tlast;

  assign acc_n = {acc_q[LEN_W-8:0], b[6:0]};
  assign cnt_n = cnt_q + CNT_W'(1);
  assign rem_n = rem_q - LEN_W'(1);

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    err_d   = err_q;
    ph_n    = phase_q;

    res.kind       = KIND_IGNORED;
    res.value      = b;
    res.cap_length = '0;
    res.cap_end    = 1'b0;
    res.status     = err_q;

    unique case (phase_q)
      PH_IGNORE: begin
      end
      PH_LEN: begin
        res.kind       = KIND_LEN;
        res.status     = ST_OK;
        res.cap_length = acc_n;
        acc_d          = acc_n;
        cnt_d          = cnt_n;
        if (b[7]) begin
          if (cnt_n >= CNT_W'(MAX_UINTVAR_BYTES) || eob) begin
            res.status = ST_BAD_UVAR;
            err_d      = ST_BAD_UVAR;
            phase_d    = PH_IGNORE;
          end
        end else if (acc_n == '0) begin
          res.status = ST_ZERO_LEN;
          err_d      = ST_ZERO_LEN;
          phase_d    = PH_IGNORE;
        end else begin
          rem_d   = acc_n;
          cnt_d   = '0;
          phase_d = PH_ID;
          if (eob) res.status = ST_TRUNCATED;
        end
      end
      PH_ID, PH_NAME, PH_DATA: begin
        res.status     = ST_OK;
        res.cap_length = acc_q;
        rem_d          = rem_n;
        if (phase_q == PH_ID && b[7]) begin
          res.kind  = KIND_ID;
          res.value = {1'b0, b[6:0]};
          ph_n      = PH_DATA;
        end else if (phase_q != PH_DATA && b == '0) begin
          res.kind = KIND_TERM;
          ph_n     = PH_DATA;
        end else if (phase_q != PH_DATA) begin
          res.kind = KIND_NAME;
          ph_n     = PH_NAME;
        end else begin
          res.kind = KIND_DATA;
        end
        phase_d = ph_n;
        if (ph_n == PH_NAME && (rem_n == '0 || eob)) begin
          res.status = ST_NO_TERM;
          err_d      = ST_NO_TERM;
          phase_d    = PH_IGNORE;
        end else if (rem_n == '0) begin
          res.cap_end = 1'b1;
          phase_d     = PH_LEN;
          acc_d       = '0;
          cnt_d       = '0;
        end else if (eob) begin
          res.status = ST_TRUNCATED;
        end
      end
      default: begin
      end
    endcase

    if (eob) begin
      phase_d = PH_LEN;
      acc_d   = '0;
      cnt_d   = '0;
      rem_d   = '0;
      err_d   = ST_OK;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_fire || !out_valid_q) begin
      out_valid_d  = skid_valid_q || in_fire;
      out_d        = skid_valid_q ? skid_q : res;
      skid_valid_d = 1'b0;
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LEN;
      acc_q        <= '0;
      cnt_q        <= '0;
      rem_q        <= '0;
      err_q        <= ST_OK;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        rem_q   <= rem_d;
        err_q   <= err_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.cap_end;
  assign m_axis_tdata  = {5'b0, out_q.status, out_q.cap_length, out_q.value};

endmodule

// ===== rtl/clp_checker.sv =====
`timescale 1ns / 1ps

module clp_checker
  import clp_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,   // value[7:0], cap_length[39:8], status[42:40]
  input logic [2:0]             m_axis_tuser,   // kind[2:0]
  input logic                   m_axis_tlast    // cap_end
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // after an accepted input item the output holds a pending result next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item left no result");

  // ignored bytes carry no length and never end a capability
  a_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_IGNORED |->
      m_axis_tdata[39:8] == '0 && !m_axis_tlast)
    else $error("ignored item with length or cap_end");

  // cap_end only on a byte inside a capability's body, with ok status
  a_cap_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tuser != KIND_LEN && m_axis_tuser != KIND_IGNORED &&
      m_axis_tdata[42:40] == ST_OK)
    else $error("cap_end on wrong kind or with error");

  // a short id never shows bit 7
  a_id_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ID |-> !m_axis_tdata[7])
    else $error("short id with bit 7 set");

endmodule

bind capability_list_parser clp_checker u_clp_checker (.*);

// ===== test/capability_list_parser_tb.sv =====
`timescale 1ns / 1ps

module capability_list_parser_tb;
  import clp_pkg::*;

  localparam int unsigned UVAR_MAX = MAX_UINTVAR_BYTES_DEF;

  typedef enum logic [2:0] {
    EXP_LEN,
    EXP_ID,
    IN_NAME,
    IN_DATA,
    SKIPPING
  } parse_phase_e;

  typedef struct packed {
    logic       eob;
    logic [7:0] octet;
  } octet_item_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OCTET_W-1:0]     s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [2:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  capability_list_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // parser state mirror
  parse_phase_e ph;
  logic [31:0]  acc;
  logic [2:0]   uv_cnt;
  logic [31:0]  remaining;
  logic         err_seen;
  status_e      err_code;

  octet_item_t  pending[$];
  result_t      expected_tags[$];
  logic [7:0]   frame_q[$];
  octet_item_t  next_item;
  int           mismatches = 0;
  int           results_seen = 0;
  int           items_total = 0;
  int           gap_left = 0;
  int           burst_left = 0;
  int           pattern_age = 0;
  logic [15:0]  ready_pattern = 16'hFFFF;
  logic         in_fire = 1'b0;

  function automatic void clear_parse();
    ph        = EXP_LEN;
    acc       = '0;
    uv_cnt    = '0;
    remaining = '0;
    err_seen  = 1'b0;
    err_code  = ST_OK;
  endfunction

  function automatic void enter_error(status_e code);
    err_seen = 1'b1;
    err_code = code;
    ph       = SKIPPING;
  endfunction

  function automatic result_t tag_octet(logic [7:0] b, logic eob);
    result_t r;
    r.kind       = KIND_IGNORED;
    r.value      = b;
    r.cap_length = '0;
    r.cap_end    = 1'b0;
    r.status     = ST_OK;
    if (err_seen || ph == SKIPPING) begin
      r.status = err_code;
    end else if (ph == EXP_LEN) begin
      r.kind       = KIND_LEN;
      acc          = {acc[24:0], b[6:0]};
      uv_cnt       = uv_cnt + 3'd1;
      r.cap_length = acc;
      if (b[7]) begin
        if (uv_cnt >= UVAR_MAX || eob) begin
          r.status = ST_BAD_UVAR;
          enter_error(ST_BAD_UVAR);
        end
      end else if (acc == 0) begin
        r.status = ST_ZERO_LEN;
        enter_error(ST_ZERO_LEN);
      end else begin
        remaining = acc;
        uv_cnt    = '0;
        ph        = EXP_ID;
        if (eob) r.status = ST_TRUNCATED;
      end
    end else begin
      r.cap_length = acc;
      remaining    = remaining - 32'd1;
      if (ph == EXP_ID) begin
        if (b[7]) begin
          r.kind  = KIND_ID;
          r.value = {1'b0, b[6:0]};
          ph      = IN_DATA;
        end else if (b == 8'h00) begin
          r.kind = KIND_TERM;
          ph     = IN_DATA;
        end else begin
          r.kind = KIND_NAME;
          ph     = IN_NAME;
        end
      end else if (ph == IN_NAME) begin
        if (b == 8'h00) begin
          r.kind = KIND_TERM;
          ph     = IN_DATA;
        end else begin
          r.kind = KIND_NAME;
        end
      end else begin
        r.kind = KIND_DATA;
      end
      if (ph == IN_NAME && (remaining == 0 || eob)) begin
        r.status = ST_NO_TERM;
        enter_error(ST_NO_TERM);
      end else if (remaining == 0) begin
        r.cap_end = 1'b1;
        ph        = EXP_LEN;
        acc       = '0;
        uv_cnt    = '0;
      end else if (eob) begin
        r.status = ST_TRUNCATED;
      end
    end
    if (eob) clear_parse();
    return r;
  endfunction

  // stimulus building
  task automatic send_buffer(input logic [7:0] bytes_in[$]);
    for (int i = 0; i < bytes_in.size(); i++) begin
      pending.push_back({1'(i == bytes_in.size() - 1), bytes_in[i]});
    end
  endtask

  task automatic add_length(input logic [34:0] len);
    int groups;
    int total;
    groups = 1;
    while (groups < 5 && (len >> (7 * groups)) != 0) groups++;
    total = groups;
    if ($urandom_range(0, 3) == 0) total = groups + $urandom_range(0, 5 - groups);
    for (int i = total - 1; i >= 0; i--) begin
      frame_q.push_back({1'(i != 0), len[7*i +: 7]});
    end
  endtask

  task automatic add_capability();
    logic [7:0] body[$];
    int         data_cnt;
    body = {};
    case ($urandom_range(0, 5))
      0, 1, 2: body.push_back(8'h80 | 8'($urandom_range(0, 127)));
      3, 4: begin
        body.push_back(8'($urandom_range(1, 127)));
        repeat ($urandom_range(0, 6)) body.push_back(8'($urandom_range(1, 255)));
        body.push_back(8'h00);
      end
      default: body.push_back(8'h00);
    endcase
    data_cnt = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 8);
    repeat (data_cnt) body.push_back(8'($urandom));
    add_length(35'(body.size()));
    foreach (body[i]) frame_q.push_back(body[i]);
  endtask

  task automatic build_buffer();
    int keep;
    int name_len;
    frame_q = {};
    repeat ($urandom_range(1, 4)) add_capability();
    case ($urandom_range(0, 11))
      0: begin
        keep = $urandom_range(1, frame_q.size());
        while (frame_q.size() > keep) void'(frame_q.pop_back());
      end
      1: frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom);
      2: begin
        frame_q = {};
        keep    = $urandom_range(0, 1);
        repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom) | {keep[0], 7'd0});
      end
      3: begin
        // wide length, buffer ends long before it is used up
        add_length({3'($urandom_range(0, 7)), 32'($urandom)});
        repeat ($urandom_range(0, 10)) frame_q.push_back(8'($urandom));
      end
      4: begin
        frame_q.push_back(8'h00);
        repeat ($urandom_range(0, 5)) frame_q.push_back(8'($urandom));
      end
      5: begin
        name_len = $urandom_range(1, 6);
        add_length(35'(name_len));
        frame_q.push_back(8'($urandom_range(1, 127)));
        repeat (name_len - 1) frame_q.push_back(8'($urandom_range(1, 255)));
        repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom));
      end
      default: ;
    endcase
    send_buffer(frame_q);
  endtask

  // sender: bursts with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (gap_left != 0 || pending.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        next_item = pending.pop_front();
        s_axis_tdata  <= next_item.octet;
        s_axis_tlast  <= next_item.eob;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: rotating ready mask, reloaded now and then
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pattern_age == 0) begin
        ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        pattern_age   <= $urandom_range(16, 96);
      end else begin
        ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
        pattern_age   <= pattern_age - 1;
      end
      m_axis_tready <= ready_pattern[0];
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni) begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got.value      = m_axis_tdata[7:0];
        got.cap_length = m_axis_tdata[39:8];
        got.status     = status_e'(m_axis_tdata[42:40]);
        got.kind       = kind_e'(m_axis_tuser);
        got.cap_end    = m_axis_tlast;
        if (expected_tags.size() == 0) begin
          mismatches++;
          $display("%0t: exp none", $time);
          $display("%0t: got kind=%0d val=%02h len=%08h end=%0b st=%0d", $time,
                   got.kind, got.value, got.cap_length, got.cap_end, got.status);
        end else begin
          want = expected_tags.pop_front();
          if (got.kind !== want.kind || got.value !== want.value ||
              got.cap_length !== want.cap_length || got.cap_end !== want.cap_end ||
              got.status !== want.status) begin
            mismatches++;
            $display("%0t: exp kind=%0d val=%02h len=%08h end=%0b st=%0d", $time,
                     want.kind, want.value, want.cap_length, want.cap_end, want.status);
            $display("%0t: got kind=%0d val=%02h len=%08h end=%0b st=%0d", $time,
                     got.kind, got.value, got.cap_length, got.cap_end, got.status);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_tags.push_back(tag_octet(s_axis_tdata, s_axis_tlast));
      end
    end
  end

  initial begin
    int directed_cnt;
    logic [7:0] q[$];
    clear_parse();
    // id + data, name + data, empty name
    q = {8'h02, 8'h85, 8'hAA, 8'h03, 8'h61, 8'h00, 8'hFF, 8'h01, 8'h00};
    send_buffer(q);
    // zero length, then a skipped byte
    q = {8'h00, 8'h55};
    send_buffer(q);
    // overlong length, then a skipped byte
    q = {8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'h12};
    send_buffer(q);
    // length cut off by buffer end
    q = {8'hFF};
    send_buffer(q);
    // name runs past its length
    q = {8'h02, 8'h41, 8'h42};
    send_buffer(q);
    // name cut off by buffer end
    q = {8'h05, 8'h41};
    send_buffer(q);
    // wide length, buffer ends right after it
    q = {8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
    send_buffer(q);
    directed_cnt = pending.size();
    while (pending.size() < directed_cnt + 1750) build_buffer();
    items_total = pending.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (results_seen < items_total) begin
      @(negedge clk_i);
    end
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && expected_tags.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
